FILE: rtl/dzhf_pkg.sv
// Shared types, codes and constants of the Doppler zig-zag heading follower.
package dzhf_pkg;

  localparam int TIME_W = 40;
  localparam int FREQ_W = 16;
  localparam int HEAD_W = 16;
  localparam int ANG_W  = 15;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 5;

  // Configuration register indexes
  localparam logic [2:0] REG_ZIG_OFFSET    = 3'd0;
  localparam logic [2:0] REG_SAMPLES       = 3'd1;
  localparam logic [2:0] REG_TOLERANCE     = 3'd2;
  localparam logic [2:0] REG_FOLLOW_SPEED  = 3'd3;
  localparam logic [2:0] REG_LEADER_SPEED  = 3'd4;
  localparam logic [2:0] REG_SOURCE_FREQ   = 3'd5;
  localparam logic [2:0] REG_SOUND_SPEED   = 3'd6;

  // Phase codes reported with each result
  localparam logic [2:0] PH_NONE   = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_ZIG    = 3'd2;
  localparam logic [2:0] PH_SECOND = 3'd3;
  localparam logic [2:0] PH_HOLD   = 3'd4;

  // Last step indexes of the sequenced units
  localparam logic [IDX_W-1:0] DIV_LAST   = 5'd29;
  localparam logic [IDX_W-1:0] MUL_LAST   = 5'd4;
  localparam logic [IDX_W-1:0] SQRT_LAST  = 5'd30;
  localparam logic [IDX_W-1:0] CORD_LAST  = 5'd19;

  localparam logic [15:0] FULL_TURN = 16'd36000;
  localparam logic [15:0] HALF_TURN = 16'd18000;
  localparam logic [32:0] DEG90_UNITS  = 33'd589824000;
  localparam logic [30:0] DEG180_UNITS = 31'd1179648000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_DIV_AVG, ST_AVG_DONE, ST_BRANCH, ST_MUL, ST_RATIO,
    ST_RDIV, ST_AX, ST_SQ, ST_SQRT, ST_CINIT, ST_CORD, ST_ANG, ST_APPLY
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DIV_AVG, OP_DIV_STEP, OP_AVG_STORE, OP_MUL, OP_RATIO,
    OP_AX_TAKE, OP_SQ, OP_SQRT_STEP, OP_CORD_INIT, OP_CORD_STEP, OP_ANG_STORE,
    OP_APPLY
  } op_t;

  typedef enum logic [1:0] {
    KIND_IDLE, KIND_FIRST, KIND_ZIG, KIND_SECOND
  } kind_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             sel;
    kind_t            kind;
  } cmd_t;

  typedef struct packed {
    logic avg_due;
    logic first_due;
    logic zig_due;
    logic need_div;
  } stat_t;

  // CORDIC rotation angles in 1/65536 centidegree
  function automatic logic [29:0] atan_units(input logic [IDX_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd294912000;
      5'd1:  v = 30'd174096719;
      5'd2:  v = 30'd91987925;
      5'd3:  v = 30'd46694507;
      5'd4:  v = 30'd23437865;
      5'd5:  v = 30'd11730358;
      5'd6:  v = 30'd5866610;
      5'd7:  v = 30'd2933484;
      5'd8:  v = 30'd1466764;
      5'd9:  v = 30'd733385;
      5'd10: v = 30'd366693;
      5'd11: v = 30'd183346;
      5'd12: v = 30'd91673;
      5'd13: v = 30'd45837;
      5'd14: v = 30'd22918;
      5'd15: v = 30'd11459;
      5'd16: v = 30'd5730;
      5'd17: v = 30'd2865;
      5'd18: v = 30'd1432;
      5'd19: v = 30'd716;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/dzhf_ctrl.sv
// Sequencer that steps the follower datapath through one tick.
module dzhf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  dzhf_pkg::stat_t stat,
  output dzhf_pkg::cmd_t  cmd
);
  import dzhf_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             sel_r, sel_nxt;
  kind_t            kind_r, kind_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 5'd1;
    sel_nxt   = sel_r;
    kind_nxt  = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cnt_nxt = '0;
        if (stat.avg_due) begin
          state_nxt = ST_DIV_AVG;
        end else begin
          kind_nxt  = KIND_IDLE;
          state_nxt = ST_APPLY;
        end
      end
      ST_DIV_AVG: begin
        if (cnt_r == DIV_LAST) state_nxt = ST_AVG_DONE;
      end
      ST_AVG_DONE: state_nxt = ST_BRANCH;
      ST_BRANCH: begin
        cnt_nxt = '0;
        sel_nxt = 1'b0;
        if (stat.first_due) begin
          kind_nxt  = KIND_FIRST;
          state_nxt = ST_MUL;
        end else if (stat.zig_due) begin
          kind_nxt  = KIND_ZIG;
          state_nxt = ST_APPLY;
        end else begin
          kind_nxt  = KIND_SECOND;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_r == MUL_LAST) state_nxt = ST_RATIO;
      end
      ST_RATIO: begin
        cnt_nxt   = '0;
        state_nxt = stat.need_div ? ST_RDIV : ST_SQ;
      end
      ST_RDIV: begin
        if (cnt_r == DIV_LAST) state_nxt = ST_AX;
      end
      ST_AX: state_nxt = ST_SQ;
      ST_SQ: begin
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt_r == SQRT_LAST) state_nxt = ST_CINIT;
      end
      ST_CINIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_CORD;
      end
      ST_CORD: begin
        if (cnt_r == CORD_LAST) state_nxt = ST_ANG;
      end
      ST_ANG: begin
        if (sel_r) begin
          state_nxt = ST_APPLY;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = ST_RATIO;
        end
      end
      ST_APPLY: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.idx  = cnt_r;
    cmd.sel  = sel_r;
    cmd.kind = kind_r;
    case (state_r)
      ST_IDLE:     cmd.op = in_tvalid ? OP_LOAD : OP_NONE;
      ST_CHECK:    cmd.op = stat.avg_due ? OP_DIV_AVG : OP_NONE;
      ST_DIV_AVG:  cmd.op = OP_DIV_STEP;
      ST_AVG_DONE: cmd.op = OP_AVG_STORE;
      ST_BRANCH:   cmd.op = OP_NONE;
      ST_MUL:      cmd.op = OP_MUL;
      ST_RATIO:    cmd.op = OP_RATIO;
      ST_RDIV:     cmd.op = OP_DIV_STEP;
      ST_AX:       cmd.op = OP_AX_TAKE;
      ST_SQ:       cmd.op = OP_SQ;
      ST_SQRT:     cmd.op = OP_SQRT_STEP;
      ST_CINIT:    cmd.op = OP_CORD_INIT;
      ST_CORD:     cmd.op = OP_CORD_STEP;
      ST_ANG:      cmd.op = OP_ANG_STORE;
      ST_APPLY:    cmd.op = out_free ? OP_APPLY : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == OP_APPLY) out_valid_nxt = 1'b1;
    else if (out_tready)    out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      kind_r      <= KIND_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_apply_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_APPLY) |-> (!out_valid_r || out_tready))
    else $error("result written over an untaken transaction");
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_CHECK))
    else $error("accepted transaction not evaluated");
  a_apply_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_APPLY) |=> out_tvalid)
    else $error("result not presented after apply");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SQRT_LAST + 5'd1)
    else $error("step counter overran");
`endif

endmodule

FILE: rtl/dzhf_dpath.sv
// Datapath: accumulator, shared divider, square root and CORDIC, heading update.
module dzhf_dpath #(
  parameter int CYCLE_PERIOD_MS = 10000,
  parameter int ZIG_DELAY_MS    = 5000
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [dzhf_pkg::CFG_W-1:0] cfg_wdata,
  input  logic [71:0]                in_tdata,
  input  dzhf_pkg::cmd_t             cmd,
  output dzhf_pkg::stat_t            stat,
  output logic [15:0]                out_course,
  output logic [4:0]                 out_user
);
  import dzhf_pkg::*;

  function automatic logic signed [33:0] shr_s(input logic signed [33:0] v,
                                               input logic [IDX_W-1:0] s);
    logic signed [33:0] a;
    a = v[33] ? -v : v;
    a = a >>> s;
    return v[33] ? -a : a;
  endfunction

  function automatic logic [15:0] wrap_h(input logic signed [17:0] h);
    logic signed [17:0] w;
    w = h;
    if (h < 0) w = h + 18'sd36000;
    else if (h >= 18'sd36000) w = h - 18'sd36000;
    return w[15:0];
  endfunction

  // configuration
  logic [14:0] zig_off_r, tol_r;
  logic [7:0]  spa_r;
  logic [13:0] vf_r, vl_r;
  logic [15:0] f0_r;
  logic [10:0] ss_r;

  // tick state
  logic [TIME_W-1:0] now_r, nft_r, nst_r;
  logic [15:0]       nav_r, avg_r, held_r;
  logic [24:0]       sum_r;
  logic [8:0]        cnt_r;
  logic [ANG_W-1:0]  tf_r, af_r, ang_t_r, ang_a_r;
  logic              side_r;

  // working registers
  logic [20:0]        c_r;
  logic [36:0]        p1_r;
  logic [37:0]        p2_r;
  logic signed [39:0] p3_r;
  logic [29:0]        den_r;
  logic               neg_r;
  logic [30:0]        ax_r;
  logic [29:0]        rem_r, feed_r, quo_r, dvs_r;
  logic [60:0]        sqn_r, sqr_r, bit_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic [15:0]        course_r;
  logic [4:0]         user_r;

  logic signed [39:0] num, num_abs;
  logic [38:0]        mag;
  logic [30:0]        dtry, dsub;
  logic               dge;
  logic [61:0]        sq_try;
  logic               sq_ge;
  logic [61:0]        ax_sq;
  logic signed [33:0] sx, sy;
  logic signed [32:0] at;
  logic [30:0]        zc;
  logic [31:0]        rnd;
  logic [ANG_W-1:0]   ang;
  logic [21:0]        c_plus;
  logic signed [22:0] c_minus;

  // apply results
  logic [15:0]        app_held, app_course, held_first;
  logic               app_side, app_done;
  logic [2:0]         app_phase;
  logic signed [17:0] off_s, h2;
  logic               side2;

  assign num = cmd.sel ? (p3_r - $signed({3'b0, p1_r}))
                       : ($signed({3'b0, p1_r}) - $signed({2'b0, p2_r}));
  assign num_abs = num[39] ? -num : num;
  assign mag     = num_abs[38:0];

  assign stat.avg_due   = cnt_r > {1'b0, spa_r};
  assign stat.first_due = now_r >= nft_r;
  assign stat.zig_due   = now_r <= nst_r;
  assign stat.need_div  = (den_r != '0) && (mag < {9'b0, den_r});

  assign dtry = {rem_r, feed_r[29]};
  assign dge  = dtry >= {1'b0, dvs_r};
  assign dsub = dtry - {1'b0, dvs_r};

  assign sq_try = {1'b0, sqr_r} + {1'b0, bit_r};
  assign sq_ge  = {1'b0, sqn_r} >= sq_try;
  assign ax_sq  = 62'(ax_r) * 62'(ax_r);

  assign sx = shr_s(cy_r, cmd.idx);
  assign sy = shr_s(cx_r, cmd.idx);
  assign at = $signed({3'b0, atan_units(cmd.idx)});

  always_comb begin
    if (cz_r < 0) zc = '0;
    else if (cz_r > $signed({2'b0, DEG180_UNITS})) zc = DEG180_UNITS;
    else zc = cz_r[30:0];
  end
  assign rnd = {1'b0, zc} + 32'd32768;
  assign ang = rnd[30:16];

  assign c_plus  = {1'b0, c_r} + {8'b0, vf_r};
  assign c_minus = $signed({2'b0, c_r}) - $signed({9'b0, vf_r});

  assign held_first = (nav_r >= FULL_TURN) ? (nav_r - FULL_TURN) : nav_r;
  assign off_s = side_r ? $signed({3'b0, zig_off_r}) : -$signed({3'b0, zig_off_r});

  // branch rules of the second measurement
  always_comb begin
    h2    = $signed({2'b0, held_r});
    side2 = side_r;
    if (f0_r > avg_r) begin
      if (side_r) begin
        if (af_r > ang_a_r) h2 = h2 - $signed({3'b0, af_r});
        else begin
          h2    = h2 + $signed({3'b0, af_r});
          side2 = 1'b0;
        end
      end else begin
        if (af_r < ang_a_r) begin
          h2    = h2 - $signed({3'b0, af_r});
          side2 = 1'b1;
        end else h2 = h2 + $signed({3'b0, af_r});
      end
    end else begin
      if (side_r) begin
        if (tf_r > ang_t_r) h2 = h2 + $signed({2'b0, HALF_TURN}) - $signed({3'b0, tf_r});
        else begin
          h2    = h2 + $signed({2'b0, HALF_TURN}) + $signed({3'b0, tf_r});
          side2 = 1'b0;
        end
      end else begin
        if (tf_r < ang_t_r) begin
          h2    = h2 + $signed({2'b0, HALF_TURN}) - $signed({3'b0, tf_r});
          side2 = 1'b1;
        end else h2 = h2 + $signed({2'b0, HALF_TURN}) + $signed({3'b0, tf_r});
      end
    end
  end

  always_comb begin
    app_held   = held_r;
    app_side   = side_r;
    app_course = held_r;
    app_done   = 1'b1;
    app_phase  = PH_NONE;
    case (cmd.kind)
      KIND_IDLE: app_done = 1'b0;
      KIND_FIRST: begin
        app_held   = held_first;
        app_course = held_first;
        app_phase  = (ang_t_r <= tol_r || ang_a_r <= tol_r) ? PH_HOLD : PH_FIRST;
      end
      KIND_ZIG: begin
        app_phase  = PH_ZIG;
        app_course = wrap_h($signed({2'b0, held_r}) + off_s);
      end
      KIND_SECOND: begin
        app_phase  = PH_SECOND;
        app_held   = wrap_h(h2);
        app_course = app_held;
        app_side   = side2;
      end
      default: app_done = 1'b0;
    endcase
  end

  // configuration and tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zig_off_r <= 15'd4500;
      spa_r     <= 8'd1;
      tol_r     <= 15'd200;
      vf_r      <= 14'd1000;
      vl_r      <= 14'd1000;
      f0_r      <= 16'd25000;
      ss_r      <= 11'd1500;
      sum_r     <= '0;
      cnt_r     <= '0;
      avg_r     <= '0;
      held_r    <= 16'd9000;
      tf_r      <= '0;
      af_r      <= '0;
      nft_r     <= 40'd5000;
      nst_r     <= 40'd5000;
      side_r    <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ZIG_OFFSET:   zig_off_r <= cfg_wdata[14:0];
          REG_SAMPLES:      spa_r     <= cfg_wdata[7:0];
          REG_TOLERANCE:    tol_r     <= cfg_wdata[14:0];
          REG_FOLLOW_SPEED: vf_r      <= cfg_wdata[13:0];
          REG_LEADER_SPEED: vl_r      <= cfg_wdata[13:0];
          REG_SOURCE_FREQ:  f0_r      <= cfg_wdata[15:0];
          REG_SOUND_SPEED:  ss_r      <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          sum_r <= sum_r + {9'b0, in_tdata[55:40]};
          cnt_r <= cnt_r + 9'd1;
        end
        OP_AVG_STORE: begin
          avg_r <= quo_r[15:0];
          sum_r <= '0;
          cnt_r <= '0;
        end
        OP_APPLY: begin
          held_r <= app_held;
          side_r <= app_side;
          if (cmd.kind == KIND_FIRST) begin
            tf_r  <= ang_t_r;
            af_r  <= ang_a_r;
            nft_r <= now_r + TIME_W'(CYCLE_PERIOD_MS);
            nst_r <= now_r + TIME_W'(ZIG_DELAY_MS);
          end
        end
        default: ;
      endcase
    end
  end

  // working registers carry no reset
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        now_r <= in_tdata[39:0];
        nav_r <= in_tdata[71:56];
      end
      OP_DIV_AVG: begin
        rem_r  <= '0;
        feed_r <= {5'b0, sum_r};
        dvs_r  <= {21'b0, cnt_r};
      end
      OP_DIV_STEP: begin
        rem_r  <= dge ? dsub[29:0] : dtry[29:0];
        feed_r <= {feed_r[28:0], 1'b0};
        quo_r  <= {quo_r[28:0], dge};
      end
      OP_MUL: begin
        case (cmd.idx)
          5'd0: c_r   <= 21'(32'(ss_r) * 32'd1000);
          5'd1: p1_r  <= 37'(c_r) * 37'(avg_r);
          5'd2: p2_r  <= 38'(f0_r) * 38'(c_plus);
          5'd3: p3_r  <= $signed({24'b0, f0_r}) * $signed({{17{c_minus[22]}}, c_minus});
          5'd4: den_r <= 30'(vl_r) * 30'(avg_r);
          default: ;
        endcase
      end
      OP_RATIO: begin
        neg_r <= num[39];
        if (den_r == '0) begin
          ax_r <= (mag != '0) ? 31'h40000000 : 31'd0;
        end else if (mag >= {9'b0, den_r}) begin
          ax_r <= 31'h40000000;
        end else begin
          rem_r  <= mag[29:0];
          feed_r <= '0;
          dvs_r  <= den_r;
        end
      end
      OP_AX_TAKE: ax_r <= {1'b0, quo_r};
      OP_SQ: begin
        sqn_r <= (61'd1 << 60) - ax_sq[60:0];
        sqr_r <= '0;
        bit_r <= 61'd1 << 60;
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          sqn_r <= sqn_r - sq_try[60:0];
          sqr_r <= (sqr_r >> 1) + bit_r;
        end else begin
          sqr_r <= sqr_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_CORD_INIT: begin
        if (neg_r) begin
          cx_r <= $signed({3'b0, sqr_r[30:0]});
          cy_r <= $signed({3'b0, ax_r});
          cz_r <= $signed(DEG90_UNITS);
        end else begin
          cx_r <= $signed({3'b0, ax_r});
          cy_r <= $signed({3'b0, sqr_r[30:0]});
          cz_r <= '0;
        end
      end
      OP_CORD_STEP: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + sx;
          cy_r <= cy_r - sy;
          cz_r <= cz_r + at;
        end else begin
          cx_r <= cx_r - sx;
          cy_r <= cy_r + sy;
          cz_r <= cz_r - at;
        end
      end
      OP_ANG_STORE: begin
        if (cmd.sel) ang_a_r <= ang;
        else         ang_t_r <= ang;
      end
      OP_APPLY: begin
        course_r <= app_course;
        user_r   <= {app_side, app_phase, app_done};
      end
      default: ;
    endcase
  end

  assign out_course = course_r;
  assign out_user   = user_r;

endmodule

FILE: rtl/doppler_zigzag_heading_follower_top.sv
// Top level of the Doppler zig-zag heading follower.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  in_      | slave     | in_tvalid/in_tready  | tdata: time_ms, measured_frequency, heading
//  out_     | master    | out_tvalid/out_tready| tdata: course_cmd; tuser: done, phase, zig
//  cfg_     | write     | cfg_we               | cfg_index, cfg_wdata
//
// Per tick: without a finished average the tick goes straight to the update; a
// zig tick adds the 30-step average divide; a measure tick adds that divide, the
// product steps and, for each bearing angle, a 30-step ratio divide (skipped when
// the ratio saturates), a 31-step square root and 20 CORDIC steps, one a cycle.
// Synchronous active-low reset; no clearing pass. A new transaction is taken
// only in idle; a finished result waits in the output register while the next
// tick is accepted, and its update holds until the old result is taken.
module doppler_zigzag_heading_follower_top #(
  parameter int CYCLE_PERIOD_MS = 10000,
  parameter int ZIG_DELAY_MS    = 5000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // time_ms[39:0], measured_frequency[55:40], heading[71:56]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // course_cmd[15:0]
  output logic [4:0]  out_tuser,  // average_done[0], phase[3:1], zig_right[4]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import dzhf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequence the tick
  dzhf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // hold state and do the arithmetic
  dzhf_dpath #(
    .CYCLE_PERIOD_MS (CYCLE_PERIOD_MS),
    .ZIG_DELAY_MS    (ZIG_DELAY_MS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_course (out_tdata),
    .out_user   (out_tuser)
  );

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the Doppler zig-zag heading follower top level.
`timescale 1ns / 1ps

module testbench;
  import dzhf_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam longint unsigned TMASK = 64'hFF_FFFF_FFFF;
  localparam longint Q30 = 64'sd1 << 30;
  localparam longint RIGHT_ANGLE = 64'sd589824000;
  localparam longint STRAIGHT_ANGLE = 64'sd1179648000;
  localparam longint PERIOD_MS = 10000;
  localparam longint ZIG_MS = 5000;

  // CORDIC rotation angles, 1/65536 centidegree
  localparam longint ROT_ANGLE [20] = '{
    294912000, 174096719, 91987925, 46694507, 23437865,
    11730358, 5866610, 2933484, 1466764, 733385,
    366693, 183346, 91673, 45837, 22918,
    11459, 5730, 2865, 1432, 716
  };

  typedef struct packed {
    logic [15:0] course;
    logic        done;
    logic [2:0]  phase;
    logic        zig;
  } steer_t;

  typedef struct packed {
    logic [39:0] t;
    logic [15:0] f;
    logic [15:0] h;
    logic        typed;
    steer_t      want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // time_ms[39:0], measured_frequency[55:40], heading[71:56]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // course_cmd[15:0]
  logic [4:0]  out_tuser;  // average_done[0], phase[3:1], zig_right[4]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  doppler_zigzag_heading_follower_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Register copies held by the predictor
  logic [14:0] zig_cd;
  logic [7:0]  avg_span;
  logic [14:0] tol_cd;
  logic [13:0] follow_mms;
  logic [13:0] lead_mms;
  logic [15:0] tone_hz;
  logic [10:0] sound_ms;

  // Predictor state
  logic [24:0]     freq_acc;
  logic [8:0]      freq_cnt;
  logic [15:0]     freq_avg;
  int              course_held;
  logic [15:0]     toward_first;
  logic [15:0]     away_first;
  longint unsigned due_first;
  longint unsigned due_second;
  logic            zig_side;

  steer_t course_q[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     quiet = 0;
  int     ready_hold = 0;
  logic [39:0] tnow;

  function automatic longint unsigned root_u64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint shift_to_zero(longint v, int s);
    return (v >= 0) ? (v >>> s) : -((-v) >>> s);
  endfunction

  // acos of num/den in centidegrees, saturated ratio, CORDIC vectoring
  function automatic logic [15:0] acos_centideg(longint num, longint den);
    longint xq, x, y, z, t;
    longint unsigned mag, ax, q;
    if (den <= 0) begin
      xq = (num > 0) ? Q30 : ((num < 0) ? -Q30 : 64'sd0);
    end else begin
      mag = (num < 0) ? longint'(-num) : longint'(num);
      if (mag >= longint'(den)) begin
        xq = (num < 0) ? -Q30 : Q30;
      end else begin
        q = (mag << 30) / longint'(den);
        xq = (num < 0) ? -longint'(q) : longint'(q);
      end
    end
    ax = (xq < 0) ? longint'(-xq) : longint'(xq);
    y = longint'(root_u64((64'd1 << 60) - ax * ax));
    if (xq < 0) begin
      x = y;
      y = -xq;
      z = RIGHT_ANGLE;
    end else begin
      x = xq;
      z = 0;
    end
    for (int i = 0; i < 20; i++) begin
      if (y > 0) begin
        t = x + shift_to_zero(y, i);
        y = y - shift_to_zero(x, i);
        z = z + ROT_ANGLE[i];
      end else begin
        t = x - shift_to_zero(y, i);
        y = y + shift_to_zero(x, i);
        z = z - ROT_ANGLE[i];
      end
      x = t;
    end
    if (z < 0) z = 0;
    if (z > STRAIGHT_ANGLE) z = STRAIGHT_ANGLE;
    return 16'((z + 32768) >>> 16);
  endfunction

  function automatic void doppler_angles(output logic [15:0] toward, output logic [15:0] away);
    longint c, vf, vl, f0, fm;
    c = longint'(sound_ms) * 1000;
    vf = longint'(follow_mms);
    vl = longint'(lead_mms);
    f0 = longint'(tone_hz);
    fm = longint'(freq_avg);
    toward = acos_centideg(c * fm - f0 * (c + vf), vl * fm);
    away = acos_centideg(f0 * (c - vf) - c * fm, vl * fm);
  endfunction

  function automatic int wrap_turn(int h);
    int r;
    r = h % 36000;
    if (r < 0) r += 36000;
    return r;
  endfunction

  // Advance the follower by one tick and return the course it should report
  function automatic steer_t follow_tick(logic [39:0] t_ms, logic [15:0] f_hz, logic [15:0] nav);
    steer_t r;
    longint unsigned now;
    int offset, h, ta, aa;
    logic [15:0] t2, a2;
    now = longint'(t_ms);
    offset = 0;
    r = '0;
    r.phase = PH_NONE;
    freq_acc = freq_acc + 25'(f_hz);
    freq_cnt = freq_cnt + 9'd1;
    if (freq_cnt > {1'b0, avg_span}) begin
      r.done = 1'b1;
      freq_avg = 16'(freq_acc / freq_cnt);
      freq_acc = '0;
      freq_cnt = '0;
      if (now >= due_first) begin
        course_held = int'(nav) % 36000;
        due_first = (now + PERIOD_MS) & TMASK;
        due_second = (now + ZIG_MS) & TMASK;
        doppler_angles(toward_first, away_first);
        r.phase = (toward_first <= {1'b0, tol_cd} || away_first <= {1'b0, tol_cd}) ?
                  PH_HOLD : PH_FIRST;
      end else if (now <= due_second) begin
        r.phase = PH_ZIG;
        offset = zig_side ? int'(zig_cd) : -int'(zig_cd);
      end else begin
        h = course_held;
        ta = int'(toward_first);
        aa = int'(away_first);
        r.phase = PH_SECOND;
        doppler_angles(t2, a2);
        if (tone_hz > freq_avg) begin
          // leader is moving away: steer on the away angle
          if (zig_side) begin
            if (away_first > a2) h -= aa;
            else begin
              h += aa;
              zig_side = 1'b0;
            end
          end else begin
            if (away_first < a2) begin
              h -= aa;
              zig_side = 1'b1;
            end else h += aa;
          end
        end else begin
          if (zig_side) begin
            if (toward_first > t2) h += 18000 - ta;
            else begin
              h += 18000 + ta;
              zig_side = 1'b0;
            end
          end else begin
            if (toward_first < t2) begin
              h += 18000 - ta;
              zig_side = 1'b1;
            end else h += 18000 + ta;
          end
        end
        course_held = wrap_turn(h);
      end
    end
    r.course = 16'(wrap_turn(course_held + offset));
    r.zig = zig_side;
    return r;
  endfunction

  // Mostly short gaps, a few long ones; none in quiet phases
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic note_mismatch(string what, steer_t want, steer_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): expected course %0d done %0b phase %0d zig %0b,",
                " got course %0d done %0b phase %0d zig %0b"},
               what, want.course, want.done, want.phase, want.zig,
               got.course, got.done, got.phase, got.zig);
  endtask

  // Offer one tick; hold it until the transaction completes, then queue its course
  task automatic send_tick(logic [39:0] t_ms, logic [15:0] f_hz, logic [15:0] nav,
                           bit typed, steer_t want);
    int gap;
    steer_t pred;
    gap = gap_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {nav, f_hz, t_ms};
    do @(posedge clk); while (!in_tready);
    pred = follow_tick(t_ms, f_hz, nav);
    course_q.insert(course_q.size(), typed ? want : pred);
  endtask

  // Write every register while the block is idle
  task automatic write_regs(logic [14:0] zo, logic [7:0] sp, logic [14:0] tol,
                            logic [13:0] vf, logic [13:0] vl, logic [15:0] f0,
                            logic [10:0] snd);
    logic [15:0] vals [7];
    logic [2:0]  idx [7];
    vals = '{16'(zo), 16'(sp), 16'(tol), 16'(vf), 16'(vl), f0, 16'(snd)};
    idx = '{REG_ZIG_OFFSET, REG_SAMPLES, REG_TOLERANCE, REG_FOLLOW_SPEED,
            REG_LEADER_SPEED, REG_SOURCE_FREQ, REG_SOUND_SPEED};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    zig_cd = zo; avg_span = sp; tol_cd = tol; follow_mms = vf;
    lead_mms = vl; tone_hz = f0; sound_ms = snd;
  endtask

  // Drain all expected results, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (course_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random ticks: time mostly advances, frequency mostly near the source tone
  task automatic random_ticks(int n);
    logic [15:0] f, h;
    int spread, fv;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 3) tnow = 40'({$urandom, $urandom});
      else tnow = tnow + 40'($urandom_range(0, 2500));
      spread = int'(tone_hz) / 50 + 2;
      if ($urandom_range(0, 99) < 80) begin
        fv = int'(tone_hz) + $urandom_range(0, 2 * spread) - spread;
        if (fv < 0) fv = 0;
        if (fv > 65535) fv = 65535;
        f = 16'(fv);
      end else f = 16'($urandom);
      h = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
      send_tick(tnow, f, h, 1'b0, '0);
    end
  endtask

  // Directed rows under the reset settings; only the obvious results are typed in
  row_t rows [20] = '{
    '{40'd0,      16'd25000, 16'd0,     1'b1, '{16'd9000,  1'b0, PH_NONE, 1'b1}},
    '{40'd5000,   16'd25000, 16'd65535, 1'b0, '0},
    '{40'd5100,   16'd0,     16'd0,     1'b1, '{16'd29535, 1'b0, PH_NONE, 1'b1}},
    '{40'd6000,   16'd0,     16'd0,     1'b1, '{16'd34035, 1'b1, PH_ZIG,  1'b1}},
    '{40'd10500,  16'd25017, 16'd100,   1'b0, '0},
    '{40'd10600,  16'd25017, 16'd100,   1'b0, '0},
    '{40'd15000,  16'd0,     16'd35999, 1'b0, '0},
    '{40'd15100,  16'd0,     16'd35999, 1'b0, '0},
    '{40'd20000,  16'd65535, 16'd0,     1'b0, '0},
    '{40'd20100,  16'd65535, 16'd0,     1'b0, '0},
    '{40'd25000,  16'd25010, 16'd18000, 1'b0, '0},
    '{40'd25100,  16'd24990, 16'd18000, 1'b0, '0},
    '{40'hFF_FFFF_FF9C, 16'd24983, 16'd36000, 1'b0, '0},
    '{40'hFF_FFFF_FFA0, 16'd24983, 16'd36000, 1'b0, '0},
    '{40'd0,      16'd25005, 16'd4500,  1'b0, '0},
    '{40'd100,    16'd25005, 16'd4500,  1'b0, '0},
    '{40'd6000,   16'd25020, 16'd9000,  1'b0, '0},
    '{40'd6100,   16'd25020, 16'd9000,  1'b0, '0},
    '{40'hFF_FFFF_FFFF, 16'd65535, 16'd35999, 1'b0, '0},
    '{40'hFF_FFFF_FFFF, 16'd65535, 16'd35999, 1'b0, '0}
  };

  // Result side: random back-pressure, compare each transaction in order
  always @(posedge clk) begin
    steer_t got, want;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else begin
      int g;
      g = gap_cycles();
      out_tready <= (g == 0);
      if (g > 0) ready_hold <= g - 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tuser[0], out_tuser[3:1], out_tuser[4]};
      if (course_q.size() == 0) begin
        note_mismatch("no course pending", '0, got);
      end else begin
        want = course_q.pop_front();
        if (got.course !== want.course) note_mismatch("course", want, got);
        else if (got.done !== want.done) note_mismatch("average done", want, got);
        else if (got.phase !== want.phase) note_mismatch("phase", want, got);
        else if (got.zig !== want.zig) note_mismatch("zig side", want, got);
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("doppler_zigzag_heading_follower_top verification failed");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_ZIG_OFFSET;
    cfg_wdata <= '0;
    // reset values of the registers and the follower state
    zig_cd = 15'd4500; avg_span = 8'd1; tol_cd = 15'd200; follow_mms = 14'd1000;
    lead_mms = 14'd1000; tone_hz = 16'd25000; sound_ms = 11'd1500;
    freq_acc = '0; freq_cnt = '0; freq_avg = '0; course_held = 9000;
    toward_first = '0; away_first = '0; due_first = 5000; due_second = 5000;
    zig_side = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_tick(rows[i].t, rows[i].f, rows[i].h, rows[i].typed, rows[i].want);
    tnow = rows[19].t;
    random_ticks(40);
    drain();

    // low extremes: zero offset and tolerance, average every tick
    write_regs(15'd0, 8'd0, 15'd0, 14'd0, 14'd1, 16'd1, 11'd1300);
    random_ticks(50);
    drain();

    // high extremes: no average finishes in these ticks
    write_regs(15'd18000, 8'd255, 15'd18000, 14'd10000, 14'd10000, 16'd65535, 11'd1700);
    random_ticks(30);
    drain();

    // a short window so the next settings start fresh
    write_regs(15'd4500, 8'd1, 15'd200, 14'd1000, 14'd1000, 16'd25000, 11'd1500);
    random_ticks(20);
    drain();

    for (int p = 0; p < 5; p++) begin
      quiet = (p == 2);
      write_regs(15'($urandom_range(0, 18000)), 8'($urandom_range(0, 3)),
                 15'($urandom_range(0, 1500)), 14'($urandom_range(0, 10000)),
                 14'($urandom_range(1, 10000)), 16'($urandom_range(1000, 65535)),
                 11'($urandom_range(1300, 1700)));
      random_ticks(55);
      drain();
    end
    quiet = 0;

    repeat (250) @(posedge clk);
    if (mismatches == 0 && course_q.size() == 0) begin
      $display("doppler_zigzag_heading_follower_top verification clean");
    end else begin
      $display("doppler_zigzag_heading_follower_top verification failed");
    end
    $finish;
  end

endmodule
